// ----- src/plm_pkg.sv -----
// plm_pkg: field widths, action codes and status codes of the positional list manager
// no dependencies; imported by positional_list_manager
package plm_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LENGTH_W = 5;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request codes
  localparam action_t ACT_INS_FRONT = 3'd0;
  localparam action_t ACT_INS_BACK  = 3'd1;
  localparam action_t ACT_INS_POS   = 3'd2;
  localparam action_t ACT_REM_FRONT = 3'd3;
  localparam action_t ACT_REM_BACK  = 3'd4;
  localparam action_t ACT_REM_POS   = 3'd5;

  // result codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

// ----- src/plm_ram.sv -----
// plm_ram: generic single-write, single-read memory with registered read data
// no dependencies; used for the slot value and link stores
module plm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/positional_list_manager.sv -----
// positional_list_manager: circular doubly linked list in a pool of slots
// depends on plm_pkg and plm_ram (value, next-link and previous-link stores)

// One request word is taken at a time. in_ready_o is high only while the
// sequencer is idle. The finished result sits in an output register, so the
// next word can be taken while it waits. An insert or remove at an inner
// position walks the next-link store one link per cycle through its single
// registered read port. An insert that reuses a freed slot first pops it
// off the free list. Freed slots are kept on a free list threaded through
// the next links, so no clearing pass is needed after reset.
module positional_list_manager #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [plm_pkg::ACTION_W-1:0]  action_i,
  input  logic [plm_pkg::POS_W-1:0]     position_i,
  input  logic signed [plm_pkg::DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [plm_pkg::STATUS_W-1:0]  status_o,
  output logic signed [plm_pkg::DATA_W-1:0] removed_value_o,
  output logic [plm_pkg::LENGTH_W-1:0]  length_o
);

  import plm_pkg::*;

  localparam int unsigned IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);
  localparam int unsigned EW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_POP2, S_IPLACE, S_WALK, S_IPREV, S_ILINK1, S_ILINK2,
    S_TAIL, S_TAIL2, S_RDAT, S_RMV, S_RFREE, S_DONE
  } state_e;

  state_e              state_q;
  logic                ins_q;
  logic [EW-1:0]       pos_q;
  logic [EW-1:0]       walk_q;
  logic                first_q;
  logic [DATA_W-1:0]   value_q;
  logic [IW-1:0]       slot_q;
  logic [IW-1:0]       cur_q;
  logic [IW-1:0]       before_q;
  logic [IW-1:0]       head_q;
  logic [IW-1:0]       free_head_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       fill_q;
  status_t             status_q;
  logic [DATA_W-1:0]   removed_q;
  logic                out_valid_q;
  status_t             out_status_q;
  logic [DATA_W-1:0]   out_removed_q;
  logic [LENGTH_W-1:0] out_length_q;

  // memory ports
  logic              val_we, nxt_we, prv_we;
  logic [IW-1:0]     val_waddr, nxt_waddr, prv_waddr;
  logic [DATA_W-1:0] val_wdata;
  logic [IW-1:0]     nxt_wdata, prv_wdata;
  logic [IW-1:0]     val_raddr, nxt_raddr, prv_raddr;
  logic [DATA_W-1:0] val_rd;
  logic [IW-1:0]     nxt_rd, prv_rd;

  plm_ram #(.WIDTH(DATA_W), .DEPTH(POOL_SIZE)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rd)
  );

  plm_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rd)
  );

  plm_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (prv_raddr),
    .rdata_o (prv_rd)
  );

  // request decode: effective position and checks
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] pos_e;
  logic          is_ins, is_rem;
  logic          ins_range, pool_full, rem_empty, rem_range;

  assign cnt_e = EW'(count_q);

  always_comb begin
    pos_e  = EW'(position_i);
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (action_t'(action_i))
      ACT_INS_FRONT: begin pos_e = EW'(1);         is_ins = 1'b1; end
      ACT_INS_BACK:  begin pos_e = cnt_e + EW'(1); is_ins = 1'b1; end
      ACT_INS_POS:   begin                         is_ins = 1'b1; end
      ACT_REM_FRONT: begin pos_e = EW'(1);         is_rem = 1'b1; end
      ACT_REM_BACK:  begin pos_e = cnt_e;          is_rem = 1'b1; end
      ACT_REM_POS:   begin                         is_rem = 1'b1; end
      default:       begin                                        end
    endcase
  end

  assign ins_range = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
  assign pool_full = (count_q == CW'(POOL_SIZE));
  assign rem_empty = (count_q == '0);
  assign rem_range = (pos_e == '0) || (pos_e > cnt_e);

  assign in_ready_o = (state_q == S_IDLE);

  // memory port control per sequencer step
  always_comb begin
    val_we    = 1'b0;
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    val_waddr = slot_q;
    nxt_waddr = slot_q;
    prv_waddr = slot_q;
    val_wdata = value_q;
    nxt_wdata = slot_q;
    prv_wdata = slot_q;
    val_raddr = cur_q;
    nxt_raddr = cur_q;
    prv_raddr = cur_q;
    case (state_q)
      S_POP: begin
        nxt_raddr = free_head_q;
      end
      S_IPLACE: begin
        val_we = 1'b1;
        if (count_q == '0) begin
          nxt_we = 1'b1;
          prv_we = 1'b1;
        end
      end
      S_WALK: begin
        nxt_raddr = first_q ? cur_q : nxt_rd;
      end
      S_ILINK1: begin
        nxt_we    = 1'b1;
        nxt_wdata = cur_q;
        prv_we    = 1'b1;
        prv_wdata = prv_rd;
      end
      S_ILINK2: begin
        nxt_we    = 1'b1;
        nxt_waddr = before_q;
        prv_we    = 1'b1;
        prv_waddr = cur_q;
      end
      S_RMV: begin
        if (count_q != CW'(1)) begin
          nxt_we    = 1'b1;
          nxt_waddr = prv_rd;
          nxt_wdata = nxt_rd;
          prv_we    = 1'b1;
          prv_waddr = nxt_rd;
          prv_wdata = prv_rd;
        end
      end
      S_RFREE: begin
        nxt_we    = 1'b1;
        nxt_waddr = cur_q;
        nxt_wdata = free_head_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer, list bookkeeping and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      free_head_q  <= '0;
      count_q      <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_removed_q <= '0;
      out_length_q <= '0;
    end else begin
      // result word taken; a word finishing now reloads the register instead
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            value_q   <= value_i;
            pos_q     <= pos_e;
            ins_q     <= is_ins;
            removed_q <= '0;
            status_q  <= ST_OK;
            cur_q     <= head_q;
            walk_q    <= pos_e - EW'(1);
            first_q   <= 1'b1;
            state_q   <= S_DONE;
            if (is_ins) begin
              if (ins_range) begin
                status_q <= ST_RANGE;
              end else if (pool_full) begin
                status_q <= ST_FULL;
              end else if (fill_q > count_q) begin
                state_q <= S_POP;
              end else begin
                slot_q  <= fill_q[IW-1:0];
                fill_q  <= fill_q + CW'(1);
                state_q <= S_IPLACE;
              end
            end else if (is_rem) begin
              if (rem_empty) begin
                status_q <= ST_EMPTY;
              end else if (rem_range) begin
                status_q <= ST_RANGE;
              end else if (pos_e == EW'(1)) begin
                state_q <= S_RDAT;
              end else if (pos_e == cnt_e) begin
                state_q <= S_TAIL;
              end else begin
                state_q <= S_WALK;
              end
            end
          end
        end
        // take a slot off the free list
        S_POP: begin
          state_q <= S_POP2;
        end
        S_POP2: begin
          slot_q      <= free_head_q;
          free_head_q <= nxt_rd;
          state_q     <= S_IPLACE;
        end
        // value written; first element links to itself
        S_IPLACE: begin
          if (count_q == '0) begin
            head_q  <= slot_q;
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end else if (pos_q == EW'(1) || pos_q == cnt_e + EW'(1)) begin
            state_q <= S_IPREV;
          end else begin
            state_q <= S_WALK;
          end
        end
        // follow next links, one per cycle
        S_WALK: begin
          if (first_q) begin
            first_q <= 1'b0;
          end else begin
            cur_q  <= nxt_rd;
            walk_q <= walk_q - EW'(1);
            if (walk_q == EW'(1)) begin
              state_q <= ins_q ? S_IPREV : S_RDAT;
            end
          end
        end
        S_IPREV: begin
          state_q <= S_ILINK1;
        end
        S_ILINK1: begin
          before_q <= prv_rd;
          state_q  <= S_ILINK2;
        end
        S_ILINK2: begin
          if (pos_q == EW'(1)) begin
            head_q <= slot_q;
          end
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        // last element is the head's predecessor
        S_TAIL: begin
          state_q <= S_TAIL2;
        end
        S_TAIL2: begin
          cur_q   <= prv_rd;
          state_q <= S_RDAT;
        end
        S_RDAT: begin
          state_q <= S_RMV;
        end
        // unlink the element
        S_RMV: begin
          removed_q <= val_rd;
          if (count_q == CW'(1)) begin
            head_q <= '0;
          end else if (pos_q == EW'(1)) begin
            head_q <= nxt_rd;
          end
          state_q <= S_RFREE;
        end
        S_RFREE: begin
          free_head_q <= cur_q;
          count_q     <= count_q - CW'(1);
          state_q     <= S_DONE;
        end
        // hand the result word to the output register
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= status_q;
            out_removed_q <= removed_q;
            out_length_q  <= LENGTH_W'(count_q);
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign length_o        = out_length_q;

endmodule
